/* design/tile_background_pixel_shifter_defines.svh */
// assertion macros for the background pixel shifter
`ifndef TILE_BACKGROUND_PIXEL_SHIFTER_DEFINES_SVH
`define TILE_BACKGROUND_PIXEL_SHIFTER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define TBPS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tbps check failed");

// checked at every edge, reset included
`define TBPS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("tbps check failed");

`else

`define TBPS_ASSERT(label, prop)
`define TBPS_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* design/tbps_pkg.sv */
package tbps_pkg;

    localparam int TILE_WIDTH = 8;
    localparam int COUNT_W    = 4;

    typedef enum logic [1:0] {
        FUNC_CLEAR    = 2'd0,
        FUNC_LINE     = 2'd1,
        FUNC_PIXEL    = 2'd2,
        FUNC_PREFETCH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_BACKDROP = 2'd1,
        ACT_COLOR    = 2'd2
    } t_action;

    localparam logic [1:0] CFG_FINE_SCROLL  = 2'd0;
    localparam logic [1:0] CFG_CLIP_LEFT    = 2'd1;
    localparam logic [1:0] CFG_LAYER_ENABLE = 2'd2;

    localparam logic [COUNT_W-1:0] RELOAD_VALUE = COUNT_W'(TILE_WIDTH);
    localparam logic [7:0]         CLIP_LAST_X  = 8'(TILE_WIDTH - 1);

    typedef struct packed {
        t_func      func;
        logic       rendering;
        logic [7:0] pixel_x;
        logic [7:0] pattern_low;
        logic [7:0] pattern_high;
        logic [7:0] attr_byte;
        logic [2:0] attr_tag;
    } t_item;

    typedef struct packed {
        logic [2:0] fine_scroll;
        logic       clip_left;
        logic       layer_enable;
    } t_cfg;

    typedef struct packed {
        logic       bg_write;
        logic [1:0] bg_pixel;
        t_action    frame_action;
        logic [3:0] frame_color;
    } t_result;

endpackage

/* design/tbps_shifter.sv */
`include "tile_background_pixel_shifter_defines.svh"

module tbps_shifter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tbps_pkg::t_item   i_item,
    input  tbps_pkg::t_cfg    i_cfg,
    output tbps_pkg::t_result o_result
);

    logic [7:0] r_low_shifter,  n_low_shifter;
    logic [7:0] r_high_shifter, n_high_shifter;
    logic [7:0] r_low_feed,     n_low_feed;
    logic [7:0] r_high_feed,    n_high_feed;
    logic [7:0] r_attr_current, n_attr_current;
    logic [2:0] r_current_shift, n_current_shift;
    logic [7:0] r_attr_next,    n_attr_next;
    logic [2:0] r_next_shift,   n_next_shift;
    logic [tbps_pkg::COUNT_W-1:0] r_reload_count, n_reload_count;

    always_comb begin
        logic [tbps_pkg::COUNT_W-1:0] count_dec;
        logic                         load;
        logic [7:0]                   low_src;
        logic [7:0]                   high_src;
        logic [2:0]                   tap;
        logic [1:0]                   pixel;
        logic [7:0]                   attr_sel;
        logic [2:0]                   shift_sel;
        logic [7:0]                   attr_shifted;

        n_low_shifter   = r_low_shifter;
        n_high_shifter  = r_high_shifter;
        n_low_feed      = r_low_feed;
        n_high_feed     = r_high_feed;
        n_attr_current  = r_attr_current;
        n_current_shift = r_current_shift;
        n_attr_next     = r_attr_next;
        n_next_shift    = r_next_shift;
        n_reload_count  = r_reload_count;
        o_result        = '0;

        count_dec    = (r_reload_count != '0) ? r_reload_count - 1'b1 : r_reload_count;
        load         = (count_dec == '0);
        low_src      = load ? i_item.pattern_low  : r_low_feed;
        high_src     = load ? i_item.pattern_high : r_high_feed;
        tap          = 3'd7 - i_cfg.fine_scroll;
        pixel        = {r_high_shifter[tap], r_low_shifter[tap]};
        attr_sel     = '0;
        shift_sel    = '0;
        attr_shifted = '0;

        case (i_item.func)
            tbps_pkg::FUNC_CLEAR: begin
                n_low_shifter   = '0;
                n_high_shifter  = '0;
                n_low_feed      = '0;
                n_high_feed     = '0;
                n_attr_current  = '0;
                n_current_shift = '0;
                n_attr_next     = '0;
                n_next_shift    = '0;
                n_reload_count  = '0;
            end
            tbps_pkg::FUNC_LINE: begin
                n_reload_count = r_reload_count + 1'b1;
            end
            tbps_pkg::FUNC_PREFETCH: begin
                n_low_shifter   = r_low_feed;
                n_high_shifter  = r_high_feed;
                n_low_feed      = i_item.pattern_low;
                n_high_feed     = i_item.pattern_high;
                n_attr_current  = r_attr_next;
                n_current_shift = r_next_shift;
                n_attr_next     = i_item.attr_byte;
                n_next_shift    = i_item.attr_tag;
                n_reload_count  = tbps_pkg::RELOAD_VALUE;
            end
            default: begin
                // pixel transaction: count down, reload at zero, then shift
                n_reload_count = load ? tbps_pkg::RELOAD_VALUE : count_dec;
                if (load) begin
                    n_attr_current  = r_attr_next;
                    n_current_shift = r_next_shift;
                    n_attr_next     = i_item.attr_byte;
                    n_next_shift    = i_item.attr_tag;
                end
                n_low_shifter  = {r_low_shifter[6:0],  low_src[7]};
                n_high_shifter = {r_high_shifter[6:0], high_src[7]};
                n_low_feed     = {low_src[6:0],  1'b0};
                n_high_feed    = {high_src[6:0], 1'b0};

                o_result.bg_write = 1'b1;
                if (i_item.rendering) begin
                    if (pixel == 2'd0 ||
                        (i_item.pixel_x <= tbps_pkg::CLIP_LAST_X && i_cfg.clip_left)) begin
                        o_result.frame_action = tbps_pkg::ACT_BACKDROP;
                    end else begin
                        o_result.bg_pixel = pixel;
                        if (i_cfg.layer_enable) begin
                            // near the tile boundary the scrolled pixel belongs to the next tile
                            if (n_reload_count <= {1'b0, i_cfg.fine_scroll}) begin
                                attr_sel  = n_attr_next;
                                shift_sel = n_next_shift;
                            end else begin
                                attr_sel  = n_attr_current;
                                shift_sel = n_current_shift;
                            end
                            attr_shifted          = attr_sel >> shift_sel;
                            o_result.frame_action = tbps_pkg::ACT_COLOR;
                            o_result.frame_color  = {attr_shifted[1:0], pixel};
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_shifter   <= '0;
            r_high_shifter  <= '0;
            r_low_feed      <= '0;
            r_high_feed     <= '0;
            r_attr_current  <= '0;
            r_current_shift <= '0;
            r_attr_next     <= '0;
            r_next_shift    <= '0;
            r_reload_count  <= '0;
        end else if (i_accept) begin
            r_low_shifter   <= n_low_shifter;
            r_high_shifter  <= n_high_shifter;
            r_low_feed      <= n_low_feed;
            r_high_feed     <= n_high_feed;
            r_attr_current  <= n_attr_current;
            r_current_shift <= n_current_shift;
            r_attr_next     <= n_attr_next;
            r_next_shift    <= n_next_shift;
            r_reload_count  <= n_reload_count;
        end
    end

    `TBPS_ASSERT(a_clear_empties, i_accept && i_item.func == tbps_pkg::FUNC_CLEAR |=> r_reload_count == '0 && r_low_shifter == '0 && r_high_feed == '0)
    `TBPS_ASSERT(a_prefetch_reload, i_accept && i_item.func == tbps_pkg::FUNC_PREFETCH |=> r_reload_count == tbps_pkg::RELOAD_VALUE && r_low_shifter == $past(r_low_feed))
    `TBPS_ASSERT(a_idle_holds, !i_accept |=> $stable(r_reload_count) && $stable(r_low_shifter) && $stable(r_attr_next))

endmodule

/* design/tile_background_pixel_shifter.sv */
// output: an accepted transaction's result is registered in the output register, or in the
// skid register while the output stalls; throughput: one transaction per cycle while the skid
// register is empty; the state update of the shifter completes in the accepting cycle
// reset: synchronous active low; shifter state cleared, fine scroll and clip cleared,
// layer enabled, output and skid registers empty
`include "tile_background_pixel_shifter_defines.svh"

module tile_background_pixel_shifter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic       i_rendering,
    input  logic [7:0] i_pixel_x,
    input  logic [7:0] i_pattern_low,
    input  logic [7:0] i_pattern_high,
    input  logic [7:0] i_attr_byte,
    input  logic [2:0] i_attr_tag,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_bg_write,
    output logic [1:0] o_bg_pixel,
    output logic [1:0] o_frame_action,
    output logic [3:0] o_frame_color,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [2:0] i_cfg_data
);

    tbps_pkg::t_cfg    r_cfg;
    tbps_pkg::t_item   item;
    tbps_pkg::t_result result;
    tbps_pkg::t_result r_out;
    tbps_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              accept;
    logic              out_free;

    assign item.func         = tbps_pkg::t_func'(i_func);
    assign item.rendering    = i_rendering;
    assign item.pixel_x      = i_pixel_x;
    assign item.pattern_low  = i_pattern_low;
    assign item.pattern_high = i_pattern_high;
    assign item.attr_byte    = i_attr_byte;
    assign item.attr_tag     = i_attr_tag;

    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fine_scroll  <= '0;
            r_cfg.clip_left    <= 1'b0;
            r_cfg.layer_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tbps_pkg::CFG_FINE_SCROLL:  r_cfg.fine_scroll  <= i_cfg_data;
                tbps_pkg::CFG_CLIP_LEFT:    r_cfg.clip_left    <= i_cfg_data[0];
                tbps_pkg::CFG_LAYER_ENABLE: r_cfg.layer_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tbps_shifter u_shifter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_bg_write     = r_out.bg_write;
    assign o_bg_pixel     = r_out.bg_pixel;
    assign o_frame_action = r_out.frame_action;
    assign o_frame_color  = r_out.frame_color;

    `TBPS_ASSERT_ALWAYS(a_skid_behind_out, r_skid_valid |-> r_out_valid)
    `TBPS_ASSERT(a_color_is_opaque, o_valid && o_frame_action == tbps_pkg::ACT_COLOR |-> o_bg_write && o_bg_pixel != 2'd0)
    `TBPS_ASSERT(a_no_write_is_quiet, o_valid && !o_bg_write |-> o_frame_action == tbps_pkg::ACT_NONE && o_bg_pixel == 2'd0 && o_frame_color == 4'd0)

endmodule

/* bench/tile_background_pixel_shifter_test.sv */
// predicts the background pixel and frame write for each accepted transaction
class bg_pixel_tracker;
    tbps_pkg::t_cfg    cfg;
    logic [7:0]        low_shift;
    logic [7:0]        high_shift;
    logic [7:0]        low_feed;
    logic [7:0]        high_feed;
    logic [7:0]        attr_cur;
    logic [7:0]        attr_nxt;
    logic [2:0]        tag_cur;
    logic [2:0]        tag_nxt;
    logic [3:0]        reload;
    tbps_pkg::t_result awaited_pixels[$];
    int                errors;

    function new();
        cfg = '0;
        cfg.layer_enable = 1'b1;
        errors = 0;
        clear_shifter();
    endfunction

    function void clear_shifter();
        low_shift  = '0;
        high_shift = '0;
        low_feed   = '0;
        high_feed  = '0;
        attr_cur   = '0;
        attr_nxt   = '0;
        tag_cur    = '0;
        tag_nxt    = '0;
        reload     = '0;
    endfunction

    function void load_tile(tbps_pkg::t_item it);
        low_feed  = it.pattern_low;
        high_feed = it.pattern_high;
        attr_cur  = attr_nxt;
        tag_cur   = tag_nxt;
        attr_nxt  = it.attr_byte;
        tag_nxt   = it.attr_tag;
        reload    = tbps_pkg::RELOAD_VALUE;
    endfunction

    function void set_reg(logic [1:0] index, logic [2:0] data);
        case (index)
            tbps_pkg::CFG_FINE_SCROLL:  cfg.fine_scroll  = data;
            tbps_pkg::CFG_CLIP_LEFT:    cfg.clip_left    = data[0];
            tbps_pkg::CFG_LAYER_ENABLE: cfg.layer_enable = data[0];
            default: ;
        endcase
    endfunction

    function void take_item(tbps_pkg::t_item it);
        tbps_pkg::t_result r;
        logic [1:0]        pix;
        logic [1:0]        pal;
        logic [7:0]        attr;
        logic [2:0]        sh;
        int unsigned       bit_sel;
        r = '0;
        case (it.func)
            tbps_pkg::FUNC_CLEAR: clear_shifter();
            tbps_pkg::FUNC_LINE:  reload = reload + 4'd1;
            tbps_pkg::FUNC_PREFETCH: begin
                low_shift  = low_feed;
                high_shift = high_feed;
                load_tile(it);
            end
            default: begin
                if (reload != 0) reload = reload - 4'd1;
                if (reload == 0) load_tile(it);
                bit_sel = 7 - cfg.fine_scroll;
                pix = {high_shift[bit_sel], low_shift[bit_sel]};
                low_shift  = {low_shift[6:0], low_feed[7]};
                high_shift = {high_shift[6:0], high_feed[7]};
                low_feed   = low_feed << 1;
                high_feed  = high_feed << 1;
                r.bg_write = 1'b1;
                // frame skip leaves only the transparent line buffer write
                if (it.rendering) begin
                    if (pix == 2'd0 ||
                        (it.pixel_x <= tbps_pkg::CLIP_LAST_X && cfg.clip_left)) begin
                        r.frame_action = tbps_pkg::ACT_BACKDROP;
                    end else begin
                        r.bg_pixel = pix;
                        if (cfg.layer_enable) begin
                            // next tile's palette while the scroll still reaches into it
                            if (reload <= cfg.fine_scroll) begin
                                attr = attr_nxt;
                                sh   = tag_nxt;
                            end else begin
                                attr = attr_cur;
                                sh   = tag_cur;
                            end
                            pal = 2'(attr >> sh);
                            r.frame_action = tbps_pkg::ACT_COLOR;
                            r.frame_color  = {pal, pix};
                        end
                    end
                end
            end
        endcase
        awaited_pixels.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void match_pixel(tbps_pkg::t_result got);
        tbps_pkg::t_result want;
        if (awaited_pixels.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, got %h", $time, got);
            errors++;
            return;
        end
        want = awaited_pixels.pop_front();
        compare_field("bg_write", want.bg_write, got.bg_write);
        compare_field("bg_pixel", want.bg_pixel, got.bg_pixel);
        compare_field("frame_action", want.frame_action, got.frame_action);
        compare_field("frame_color", want.frame_color, got.frame_color);
    endfunction

    function int pending();
        return awaited_pixels.size();
    endfunction
endclass

module tile_background_pixel_shifter_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 100;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_func;
    logic       i_rendering;
    logic [7:0] i_pixel_x;
    logic [7:0] i_pattern_low;
    logic [7:0] i_pattern_high;
    logic [7:0] i_attr_byte;
    logic [2:0] i_attr_tag;
    logic       o_valid;
    logic       i_stall;
    logic       o_bg_write;
    logic [1:0] o_bg_pixel;
    logic [1:0] o_frame_action;
    logic [3:0] o_frame_color;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [2:0] i_cfg_data;

    bg_pixel_tracker tracker;
    int              cycle_count;
    int unsigned     items_sent;
    bit              sender_eager;
    bit              receiver_eager;
    bit              long_hold;

    tile_background_pixel_shifter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_rendering    (i_rendering),
        .i_pixel_x      (i_pixel_x),
        .i_pattern_low  (i_pattern_low),
        .i_pattern_high (i_pattern_high),
        .i_attr_byte    (i_attr_byte),
        .i_attr_tag     (i_attr_tag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_bg_write     (o_bg_write),
        .o_bg_pixel     (o_bg_pixel),
        .o_frame_action (o_frame_action),
        .o_frame_color  (o_frame_color),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tile_background_pixel_shifter verification failed");
            $finish;
        end
    end

    function automatic tbps_pkg::t_item make_item(tbps_pkg::t_func f, logic r,
                                                  logic [7:0] x, logic [7:0] pl,
                                                  logic [7:0] ph, logic [7:0] ab,
                                                  logic [2:0] tag);
        tbps_pkg::t_item it;
        it.func         = f;
        it.rendering    = r;
        it.pixel_x      = x;
        it.pattern_low  = pl;
        it.pattern_high = ph;
        it.attr_byte    = ab;
        it.attr_tag     = tag;
        return it;
    endfunction

    function automatic tbps_pkg::t_item draw_item(tbps_pkg::t_func f, logic [7:0] x);
        tbps_pkg::t_item it;
        it.func         = f;
        it.rendering    = ($urandom_range(0, 5) != 0);
        it.pixel_x      = x;
        it.pattern_low  = 8'($urandom);
        it.pattern_high = 8'($urandom);
        it.attr_byte    = 8'($urandom);
        it.attr_tag     = 3'($urandom_range(0, 6));
        return it;
    endfunction

    // entered and left at a falling edge
    task automatic offer_item(tbps_pkg::t_item it);
        int unsigned gap;
        gap = sender_eager ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func         = it.func;
        i_rendering    = it.rendering;
        i_pixel_x      = it.pixel_x;
        i_pattern_low  = it.pattern_low;
        i_pattern_high = it.pattern_high;
        i_attr_byte    = it.attr_byte;
        i_attr_tag     = it.attr_tag;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (o_stall);
        tracker.take_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // block is idle here, so register writes cannot overtake a transaction
    task automatic set_config(logic [2:0] fine, logic clip, logic layer);
        i_cfg_we    = 1'b1;
        i_cfg_index = tbps_pkg::CFG_FINE_SCROLL;
        i_cfg_data  = fine;
        @(posedge i_clk);
        tracker.set_reg(tbps_pkg::CFG_FINE_SCROLL, fine);
        @(negedge i_clk);
        i_cfg_index = tbps_pkg::CFG_CLIP_LEFT;
        i_cfg_data  = {2'b00, clip};
        @(posedge i_clk);
        tracker.set_reg(tbps_pkg::CFG_CLIP_LEFT, {2'b00, clip});
        @(negedge i_clk);
        i_cfg_index = tbps_pkg::CFG_LAYER_ENABLE;
        i_cfg_data  = {2'b00, layer};
        @(posedge i_clk);
        tracker.set_reg(tbps_pkg::CFG_LAYER_ENABLE, {2'b00, layer});
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic settle();
        i_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // mostly well-formed scanlines: line starts, two prefetch loads, a run of pixels
    task automatic run_phase(logic [2:0] fine, logic clip, logic layer,
                             bit eager_tx, bit eager_rx, bit hold_off);
        int unsigned target;
        int unsigned roll;
        int unsigned n;
        logic [7:0]  x;
        set_config(fine, clip, layer);
        sender_eager   = eager_tx;
        receiver_eager = eager_rx;
        long_hold      = hold_off;
        target = items_sent + 65;
        while (items_sent < target) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    offer_item(draw_item(tbps_pkg::t_func'($urandom_range(0, 3)),
                                         8'($urandom)));
                end
            end else begin
                if (roll == 1) offer_item(draw_item(tbps_pkg::FUNC_CLEAR, 8'($urandom)));
                n = $urandom_range(0, 2);
                repeat (n) offer_item(draw_item(tbps_pkg::FUNC_LINE, 8'($urandom)));
                offer_item(draw_item(tbps_pkg::FUNC_PREFETCH, 8'($urandom)));
                offer_item(draw_item(tbps_pkg::FUNC_PREFETCH, 8'($urandom)));
                x = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
                n = $urandom_range(4, 40);
                repeat (n) begin
                    offer_item(draw_item(tbps_pkg::FUNC_PIXEL, x));
                    x++;
                end
            end
        end
        settle();
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
    endtask

    // result side
    initial begin
        int unsigned hold;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                hold = LONG_HOLD;
                long_hold = 1'b0;
            end else begin
                hold = receiver_eager ? 0 : $urandom_range(0, 16);
            end
            if (hold != 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            tracker.match_pixel({o_bg_write, o_bg_pixel, o_frame_action, o_frame_color});
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = tbps_pkg::FUNC_CLEAR;
        i_rendering    = 1'b0;
        i_pixel_x      = '0;
        i_pattern_low  = '0;
        i_pattern_high = '0;
        i_attr_byte    = '0;
        i_attr_tag     = '0;
        i_stall        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = tbps_pkg::CFG_FINE_SCROLL;
        i_cfg_data     = '0;
        items_sent     = 0;
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
        long_hold      = 1'b0;
        tracker = new();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // default settings: opaque pixels, right and left edges, frame skip, clear
        set_config(3'd0, 1'b0, 1'b1);
        offer_item(make_item(tbps_pkg::FUNC_PREFETCH, 1'b0, 8'd0, 8'hFF, 8'h00, 8'hE4, 3'd0));
        offer_item(make_item(tbps_pkg::FUNC_PREFETCH, 1'b0, 8'd0, 8'h0F, 8'hF0, 8'h1B, 3'd6));
        offer_item(make_item(tbps_pkg::FUNC_LINE, 1'b0, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd0, 8'hAA, 8'h55, 8'hC6, 3'd3));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd255, 8'h00, 8'hFF, 8'hFF, 3'd5));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b0, 8'd1, 8'hFF, 8'hFF, 8'hFF, 3'd6));
        offer_item(make_item(tbps_pkg::FUNC_CLEAR, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd8, 8'hFF, 8'hFF, 8'hFF, 3'd1));
        settle();

        // widest scroll, left clipping, layer off
        set_config(3'd7, 1'b1, 1'b0);
        offer_item(make_item(tbps_pkg::FUNC_PREFETCH, 1'b0, 8'd0, 8'hFF, 8'hFF, 8'h93, 3'd2));
        offer_item(make_item(tbps_pkg::FUNC_PREFETCH, 1'b0, 8'd0, 8'hFF, 8'hFF, 8'h6C, 3'd4));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd7, 8'h00, 8'h00, 8'h00, 3'd0));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd8, 8'h00, 8'h00, 8'h00, 3'd0));
        settle();

        // layer back on: palette taken from the next tile's attribute
        set_config(3'd7, 1'b1, 1'b1);
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd9, 8'h00, 8'h00, 8'h00, 3'd0));
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd10, 8'h00, 8'h00, 8'h00, 3'd0));
        // reload counter wraps through eight line starts after a prefetch
        offer_item(make_item(tbps_pkg::FUNC_PREFETCH, 1'b0, 8'd0, 8'hC3, 8'h3C, 8'hB1, 3'd1));
        repeat (8) begin
            offer_item(make_item(tbps_pkg::FUNC_LINE, 1'b0, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0));
        end
        offer_item(make_item(tbps_pkg::FUNC_PIXEL, 1'b1, 8'd20, 8'h5A, 8'hA5, 8'hD2, 3'd6));
        settle();

        run_phase(3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        run_phase(3'd7, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        run_phase(3'd3, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(3'd5, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(3'd7, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
        run_phase(3'd1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
        run_phase(3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        run_phase(3'd4, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        repeat (4) @(negedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tile_background_pixel_shifter verification clean");
        end else begin
            $display("tile_background_pixel_shifter verification failed");
        end
        $finish;
    end

endmodule
